@@ hdl/cmcl_pkg.sv @@
// ----------------------------------------------------------------------------
// cmcl_pkg
// Shared widths, state encoding and controller/datapath interface types for
// the collatz range maximum block.
// ----------------------------------------------------------------------------
package cmcl_pkg;

   localparam int VALUE_BITS = 20;
   localparam int TRAJ_BITS  = 40;
   localparam int LEN_BITS   = 10;

   localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
   localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_TRAJ,
      ST_PUBLISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // latch ordered bounds, start first trajectory
      logic step;     // one trajectory step
      logic finish;   // fold trajectory length into the running maximum
      logic advance;  // move on to the next start value
      logic publish;  // write result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic traj_end;   // trajectory reached one (or zero) or left the trajectory width
      logic last_value; // current start value is the upper bound
      logic rsp_busy;   // result register holds an untaken result
   } status_type;

endpackage

@@ hdl/cmcl_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmcl_ctrl
// Sequencer: walks the start values of the range and the steps of each
// trajectory by commanding the datapath.
// ----------------------------------------------------------------------------
module cmcl_ctrl
   import cmcl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_TRAJ;
            end
         end
         ST_TRAJ: begin
            if (status.traj_end && status.last_value) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_TRAJ: begin
            if (status.traj_end) begin
               cmd.finish  = 1'b1;
               cmd.advance = !status.last_value;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_PUBLISH: begin
            cmd.publish = !status.rsp_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

@@ hdl/cmcl_datapath.sv @@
// ----------------------------------------------------------------------------
// cmcl_datapath
// Range counter, trajectory register with its step adder, length counter,
// running maximum and the result register.
// ----------------------------------------------------------------------------
module cmcl_datapath
   import cmcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [VALUE_BITS-1:0] req_bound_a,
   input  logic [VALUE_BITS-1:0] req_bound_b,
   input  cmd_type               cmd,
   output status_type            status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEN_BITS-1:0]   rsp_max_length,
   output logic                  rsp_overflow
);

   logic [VALUE_BITS-1:0] cur_ff, cur_in;
   logic [VALUE_BITS-1:0] hi_ff, hi_in;
   logic [TRAJ_BITS-1:0]  n_ff, n_in;
   logic [LEN_BITS-1:0]   len_ff, len_in;
   logic [LEN_BITS-1:0]   best_ff, best_in;
   logic                  ovf_ff, ovf_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [LEN_BITS-1:0]   rsp_len_ff, rsp_len_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;

   logic [VALUE_BITS-1:0] lo_val;
   logic [VALUE_BITS-1:0] cur_next;
   logic                  odd;
   logic [TRAJ_BITS:0]    odd_sum;
   logic                  step_ovf;
   logic [LEN_BITS:0]     len_sum;
   logic [LEN_BITS-1:0]   len_sat;

   assign lo_val   = (req_bound_a < req_bound_b) ? req_bound_a : req_bound_b;
   assign cur_next = cur_ff + VALUE_BITS'(1);

   // odd step: n + n/2 + 1 = (3n + 1) / 2, carry out means it left the width
   assign odd      = n_ff[0];
   assign odd_sum  = {1'b0, n_ff} + {2'b00, n_ff[TRAJ_BITS-1:1]} + (TRAJ_BITS+1)'(1);
   assign step_ovf = odd && odd_sum[TRAJ_BITS];
   assign len_sum  = {1'b0, len_ff} + (odd ? (LEN_BITS+1)'(2) : (LEN_BITS+1)'(1));
   assign len_sat  = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];

   assign status.traj_end   = (n_ff[TRAJ_BITS-1:1] == '0) || step_ovf;
   assign status.last_value = (cur_ff == hi_ff);
   assign status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      cur_in  = cur_ff;
      hi_in   = hi_ff;
      n_in    = n_ff;
      len_in  = len_ff;
      best_in = best_ff;
      ovf_in  = ovf_ff;
      if (cmd.load) begin
         cur_in  = lo_val;
         hi_in   = (req_bound_a < req_bound_b) ? req_bound_b : req_bound_a;
         n_in    = {{(TRAJ_BITS-VALUE_BITS){1'b0}}, lo_val};
         len_in  = LEN_ONE;
         best_in = '0;
         ovf_in  = 1'b0;
      end
      if (cmd.step) begin
         n_in   = odd ? odd_sum[TRAJ_BITS-1:0] : {1'b0, n_ff[TRAJ_BITS-1:1]};
         len_in = len_sat;
      end
      if (cmd.finish) begin
         best_in = (len_ff > best_ff) ? len_ff : best_ff;
         ovf_in  = ovf_ff || step_ovf;
      end
      if (cmd.advance) begin
         cur_in = cur_next;
         n_in   = {{(TRAJ_BITS-VALUE_BITS){1'b0}}, cur_next};
         len_in = LEN_ONE;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
         rsp_len_in   = best_ff;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      hi_ff      <= hi_in;
      n_ff       <= n_in;
      len_ff     <= len_in;
      best_ff    <= best_in;
      ovf_ff     <= ovf_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_max_length = rsp_len_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   // result register must never be overwritten while a transfer is pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && !rsp_ready))
      else $error("publish while result still pending");

   // a new trajectory starts from the start value with length one
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.advance) |=>
         (len_ff == LEN_ONE) && (n_ff == {{(TRAJ_BITS-VALUE_BITS){1'b0}}, cur_ff}))
      else $error("trajectory not seeded from start value");

   // advancing only happens below the upper bound
   assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (cur_ff != hi_ff))
      else $error("advance past upper bound");

   // step and finish are exclusive
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.step && cmd.finish))
      else $error("step and finish in one cycle");

endmodule

@@ hdl/collatz_max_cycle_length_top.sv @@
// Sequence: a load, then for each start value in the range the trajectory
//   steps plus a closing step, then the result write (held while busy).
// Throughput: one range at a time; the single-step trajectory adder sets the rate.
// A new range is taken while the previous result still waits to be taken.
// Reset (synchronous, active high) clears the sequencer and result valid only.
// ----------------------------------------------------------------------------
// collatz_max_cycle_length_top
// Greatest collatz cycle length over an inclusive range of start values.
// ----------------------------------------------------------------------------
module collatz_max_cycle_length_top
   import cmcl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_bound_a,
   input  logic [VALUE_BITS-1:0] req_bound_b,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [LEN_BITS-1:0]   rsp_max_length,
   output logic                  rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   cmcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cmcl_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_bound_a    (req_bound_a),
      .req_bound_b    (req_bound_b),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_max_length (rsp_max_length),
      .rsp_overflow   (rsp_overflow)
   );

endmodule
